/* rtl/disparity_error_statistics_defines.svh */
// ----------------------------------------------------------------------------
// Disparity error statistics: assertion macros
// Shared checks, clocked on clk and held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef DISPARITY_ERROR_STATISTICS_DEFINES_SVH
`define DISPARITY_ERROR_STATISTICS_DEFINES_SVH

`ifndef ASSERT_OFF
`define DSTAT_ASSERT_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("check failed");
`define DSTAT_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("check failed");
`define DSTAT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("check failed");
`else
`define DSTAT_ASSERT_NEVER(lbl, expr)
`define DSTAT_ASSERT_IMPL(lbl, ante, cons)
`define DSTAT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* rtl/dstat_pkg.sv */
// ----------------------------------------------------------------------------
// Disparity error statistics: package
// Shared constants, register indexes and controller types.
// ----------------------------------------------------------------------------
package dstat_pkg;

	localparam int DEF_MAX_PIXELS_LOG2 = 22;
	localparam int DEF_FRAC_BITS       = 4;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_LOG2    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISP      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BAD_THRESHOLD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ROUND_ENABLE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_USE_MASK      = 3'd4;

	localparam int CNT_OUT_W = 23;
	localparam int ERR_OUT_W = 38;
	localparam int PCT_W     = 14;
	localparam int AVG_W     = 16;

	localparam logic [PCT_W-1:0] PCT_FULL = 14'd10000;
	localparam logic [AVG_W-1:0] AVG_MAX  = 16'hFFFF;
	localparam logic [7:0]       MASK_EVAL = 8'hFF;

	typedef enum logic [1:0] {
		ST_ACCUM,
		ST_START,
		ST_WAIT,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		OP_COV,
		OP_BAD,
		OP_INV,
		OP_TOT,
		OP_AVG
	} op_t;

	typedef struct packed {
		logic accept;
		logic div_start;
		logic store;
		op_t  op;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic last_seen;
		logic div_done;
		logic out_free;
	} ctrl_sts_t;

endpackage

/* rtl/disparity_error_statistics.sv */
// ----------------------------------------------------------------------------
// Disparity error statistics: top level
// Per-frame bad-pixel statistics of an estimated disparity map.
// ----------------------------------------------------------------------------
//  channel  | direction | transfer when          | payload
//  ---------+-----------+------------------------+-------------------------------
//  in       | sink      | in_valid & !in_stall   | one truth pixel + estimate
//  out      | source    | out_valid & !out_stall | one frame summary
//  cfg      | sink      | cfg_we                 | register cfg_index <= cfg_data
//
//  Pixels are taken one per cycle. The pixel flagged last_pixel closes the
//  frame: input then stalls for five serial divisions in the shared divider
//  and for the hand-off of the summary to the output register.
//  The summary waits in the output register while the next frame streams in;
//  a second frame end stalls until the first summary is transferred.
//  Reset clears all totals and sets registers to their defaults.
//
`include "disparity_error_statistics_defines.svh"

module disparity_error_statistics import dstat_pkg::*; #(
	parameter int MAX_PIXELS_LOG2 = DEF_MAX_PIXELS_LOG2,
	parameter int FRAC_BITS       = DEF_FRAC_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  truth_known,
	input  logic [15:0]           truth_disp,
	input  logic                  est_valid,
	input  logic signed [15:0]    est_disp,
	input  logic [7:0]            mask_value,
	input  logic                  last_pixel,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [CNT_OUT_W-1:0]  evaluated_count,
	output logic [CNT_OUT_W-1:0]  bad_count,
	output logic [CNT_OUT_W-1:0]  invalid_count,
	output logic [ERR_OUT_W-1:0]  error_sum,
	output logic [PCT_W-1:0]      coverage_pct,
	output logic [PCT_W-1:0]      bad_pct,
	output logic [PCT_W-1:0]      invalid_pct,
	output logic [PCT_W-1:0]      total_bad_pct,
	output logic [AVG_W-1:0]      avg_error,
	output logic                  divide_by_zero
);

	// numerator holds the error sum or a count times 10000
	localparam int NW = MAX_PIXELS_LOG2 + 16;
	localparam int CW = MAX_PIXELS_LOG2 + 1;

	ctrl_cmd_t     cmd;
	ctrl_sts_t     sts;
	logic [NW-1:0] div_num;
	logic [CW-1:0] div_den;
	logic [NW-1:0] div_quot;
	logic          div_done;
	logic          out_free;

	assign in_stall      = !cmd.accept;
	// frame end seen on an actual transfer
	assign sts.last_seen = in_valid && cmd.accept && last_pixel;
	assign sts.div_done  = div_done;
	assign sts.out_free  = out_free;

	dstat_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	dstat_datapath #(
		.MAX_PIXELS_LOG2 (MAX_PIXELS_LOG2),
		.FRAC_BITS       (FRAC_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.truth_known     (truth_known),
		.truth_disp      (truth_disp),
		.est_valid       (est_valid),
		.est_disp        (est_disp),
		.mask_value      (mask_value),
		.cmd             (cmd),
		.div_num         (div_num),
		.div_den         (div_den),
		.div_quot        (div_quot),
		.out_free        (out_free),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.evaluated_count (evaluated_count),
		.bad_count       (bad_count),
		.invalid_count   (invalid_count),
		.error_sum       (error_sum),
		.coverage_pct    (coverage_pct),
		.bad_pct         (bad_pct),
		.invalid_pct     (invalid_pct),
		.total_bad_pct   (total_bad_pct),
		.avg_error       (avg_error),
		.divide_by_zero  (divide_by_zero)
	);

	// shared divider, one quotient bit per cycle
	dstat_div #(
		.NW   (NW),
		.DENW (CW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.quot   (div_quot),
		.done   (div_done)
	);

	// no pixel is taken straight after a frame end
	`DSTAT_ASSERT_NEXT(a_stall_after_last, sts.last_seen, in_stall)
	// a new summary only appears after the frame-end stall
	`DSTAT_ASSERT_IMPL(a_result_after_stall, $rose(out_valid), $past(in_stall))
	// percentages never exceed full scale
	`DSTAT_ASSERT_NEVER(a_pct_range, out_valid && (coverage_pct > PCT_FULL ||
		bad_pct > PCT_FULL || invalid_pct > PCT_FULL || total_bad_pct > PCT_FULL))

endmodule

/* rtl/dstat_div.sv */
// ----------------------------------------------------------------------------
// Disparity error statistics: serial divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dstat_div import dstat_pkg::*; #(
	parameter int NW = DEF_MAX_PIXELS_LOG2 + 16,
	parameter int DENW = DEF_MAX_PIXELS_LOG2 + 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [NW-1:0]   num,
	input  logic [DENW-1:0] den,
	output logic [NW-1:0]   quot,
	output logic            done
);

	localparam int CNTW = $clog2(NW + 1);

	logic [NW-1:0]   nq_q;
	logic [DENW-1:0] rem_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [DENW:0]   trial;
	logic            qbit;

	assign trial = {rem_q, nq_q[NW-1]};
	assign qbit  = (trial >= {1'b0, den});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			nq_q  <= num;
			rem_q <= '0;
		end else if (busy_q) begin
			nq_q <= {nq_q[NW-2:0], qbit};
			if (qbit) begin
				rem_q <= DENW'(trial - {1'b0, den});
			end else begin
				rem_q <= trial[DENW-1:0];
			end
		end
	end

	assign quot = nq_q;
	assign done = done_q;

endmodule

/* rtl/dstat_ctrl.sv */
// ----------------------------------------------------------------------------
// Disparity error statistics: controller
// Sequences the per-frame divisions and the result hand-off.
// ----------------------------------------------------------------------------
module dstat_ctrl import dstat_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  ctrl_sts_t sts,
	output ctrl_cmd_t cmd
);

	state_t state_q, state_n;
	op_t    op_q, op_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCUM;
			op_q    <= OP_COV;
		end else begin
			state_q <= state_n;
			op_q    <= op_n;
		end
	end

	always_comb begin
		state_n       = state_q;
		op_n          = op_q;
		cmd.accept    = 1'b0;
		cmd.div_start = 1'b0;
		cmd.store     = 1'b0;
		cmd.op        = op_q;
		cmd.out_load  = 1'b0;
		unique case (state_q)
			ST_ACCUM: begin
				cmd.accept = 1'b1;
				if (sts.last_seen) begin
					op_n    = OP_COV;
					state_n = ST_START;
				end
			end
			ST_START: begin
				cmd.div_start = 1'b1;
				state_n       = ST_WAIT;
			end
			ST_WAIT: begin
				if (sts.div_done) begin
					cmd.store = 1'b1;
					unique case (op_q)
						OP_COV:  op_n = OP_BAD;
						OP_BAD:  op_n = OP_INV;
						OP_INV:  op_n = OP_TOT;
						OP_TOT:  op_n = OP_AVG;
						OP_AVG:  op_n = OP_COV;
						default: op_n = OP_COV;
					endcase
					state_n = (op_q == OP_AVG) ? ST_OUT : ST_START;
				end
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_n      = ST_ACCUM;
				end
			end
			default: state_n = ST_ACCUM;
		endcase
	end

endmodule

/* rtl/dstat_datapath.sv */
// ----------------------------------------------------------------------------
// Disparity error statistics: datapath
// Config registers, per-pixel error path, frame totals, operands and results.
// ----------------------------------------------------------------------------
module dstat_datapath import dstat_pkg::*; #(
	parameter int MAX_PIXELS_LOG2 = DEF_MAX_PIXELS_LOG2,
	parameter int FRAC_BITS       = DEF_FRAC_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data,
	input  logic                         in_valid,
	input  logic                         truth_known,
	input  logic [15:0]                  truth_disp,
	input  logic                         est_valid,
	input  logic signed [15:0]           est_disp,
	input  logic [7:0]                   mask_value,
	input  ctrl_cmd_t                    cmd,
	output logic [MAX_PIXELS_LOG2+15:0]  div_num,
	output logic [MAX_PIXELS_LOG2:0]     div_den,
	input  logic [MAX_PIXELS_LOG2+15:0]  div_quot,
	output logic                         out_free,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [CNT_OUT_W-1:0]         evaluated_count,
	output logic [CNT_OUT_W-1:0]         bad_count,
	output logic [CNT_OUT_W-1:0]         invalid_count,
	output logic [ERR_OUT_W-1:0]         error_sum,
	output logic [PCT_W-1:0]             coverage_pct,
	output logic [PCT_W-1:0]             bad_pct,
	output logic [PCT_W-1:0]             invalid_pct,
	output logic [PCT_W-1:0]             total_bad_pct,
	output logic [AVG_W-1:0]             avg_error,
	output logic                         divide_by_zero
);

	localparam int CW   = MAX_PIXELS_LOG2 + 1;
	localparam int EW   = MAX_PIXELS_LOG2 + 16;
	localparam int NW   = EW;
	localparam int DW   = (12 + FRAC_BITS > 17) ? 12 + FRAC_BITS : 17;
	localparam int RW   = DW + 1;
	localparam int HALF = (1 << FRAC_BITS) >> 1;
	localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};
	localparam logic [EW-1:0] ERR_MAX = {EW{1'b1}};
	localparam logic [RW-1:0] FRAC_MASK = RW'((1 << FRAC_BITS) - 1);

	// configuration
	logic [1:0]  scale_q;
	logic [9:0]  max_disp_q;
	logic [15:0] thr_q;
	logic        round_q;
	logic        use_mask_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q    <= 2'd0;
			max_disp_q <= 10'd1023;
			thr_q      <= 16'd16;
			round_q    <= 1'b0;
			use_mask_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SCALE_LOG2:    scale_q    <= cfg_data[1:0];
				CFG_MAX_DISP:      max_disp_q <= cfg_data[9:0];
				CFG_BAD_THRESHOLD: thr_q      <= cfg_data;
				CFG_ROUND_ENABLE:  round_q    <= cfg_data[0];
				CFG_USE_MASK:      use_mask_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// per-pixel error
	logic [1:0]         shift;
	logic signed [17:0] scaled;
	logic [DW-1:0]      maxd;
	logic [DW-1:0]      clip;
	logic [RW-1:0]      rsum;
	logic [RW-1:0]      dest;
	logic [RW-1:0]      truth_x;
	logic [RW-1:0]      err;
	logic               evaluate;
	logic               is_bad;
	logic               fire;

	assign shift   = (scale_q == 2'd3) ? 2'd2 : scale_q;
	assign scaled  = $signed({{2{est_disp[15]}}, est_disp}) <<< shift;
	assign maxd    = (DW'(max_disp_q) << shift) << FRAC_BITS;

	always_comb begin
		if (scaled[17]) begin
			clip = '0;
		end else if (DW'(scaled[16:0]) > maxd) begin
			clip = maxd;
		end else begin
			clip = DW'(scaled[16:0]);
		end
	end

	assign rsum    = RW'(clip) + RW'(HALF);
	assign dest    = round_q ? (rsum & ~FRAC_MASK) : RW'(clip);
	assign truth_x = RW'(truth_disp);
	assign err     = (dest > truth_x) ? dest - truth_x : truth_x - dest;
	assign is_bad  = err > RW'(thr_q);
	assign evaluate = truth_known && (!use_mask_q || mask_value == MASK_EVAL);
	assign fire    = in_valid && cmd.accept;

	// frame totals
	logic [CW-1:0] pix_q, eval_q, bad_q, inv_q;
	logic [EW-1:0] err_q;
	logic [EW:0]   err_add;

	assign err_add = {1'b0, err_q} + (EW + 1)'(err);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_q  <= '0;
			eval_q <= '0;
			bad_q  <= '0;
			inv_q  <= '0;
			err_q  <= '0;
		end else if (cmd.out_load) begin
			pix_q  <= '0;
			eval_q <= '0;
			bad_q  <= '0;
			inv_q  <= '0;
			err_q  <= '0;
		end else if (fire) begin
			pix_q <= (pix_q == CNT_MAX) ? pix_q : pix_q + 1'b1;
			if (evaluate) begin
				eval_q <= (eval_q == CNT_MAX) ? eval_q : eval_q + 1'b1;
				if (est_valid) begin
					err_q <= err_add[EW] ? ERR_MAX : err_add[EW-1:0];
					if (is_bad) begin
						bad_q <= (bad_q == CNT_MAX) ? bad_q : bad_q + 1'b1;
					end
				end else begin
					inv_q <= (inv_q == CNT_MAX) ? inv_q : inv_q + 1'b1;
				end
			end
		end
	end

	// operand selection; one constant multiply, registered in the divider
	logic [CW-1:0] valid_n;
	logic [CW:0]   pct_src;
	logic [NW-1:0] pct_num;

	assign valid_n = (eval_q > inv_q) ? eval_q - inv_q : '0;

	always_comb begin
		unique case (cmd.op)
			OP_COV: begin
				pct_src = {1'b0, eval_q};
				div_den = pix_q;
			end
			OP_BAD: begin
				pct_src = {1'b0, bad_q};
				div_den = eval_q;
			end
			OP_INV: begin
				pct_src = {1'b0, inv_q};
				div_den = eval_q;
			end
			OP_TOT: begin
				pct_src = {1'b0, bad_q} + {1'b0, inv_q};
				div_den = eval_q;
			end
			OP_AVG: begin
				pct_src = '0;
				div_den = valid_n;
			end
			default: begin
				pct_src = '0;
				div_den = valid_n;
			end
		endcase
	end

	assign pct_num = NW'(pct_src) * NW'(PCT_FULL);
	assign div_num = (cmd.op == OP_AVG) ? err_q : pct_num;

	// result capture
	logic [PCT_W-1:0] pct_cap;
	logic [AVG_W-1:0] avg_cap;
	logic             den_zero;
	logic [PCT_W-1:0] cov_q, bp_q, ip_q, tp_q;
	logic [AVG_W-1:0] avg_q;
	logic             dz_q;

	assign den_zero = (div_den == '0);
	assign pct_cap  = (div_quot > NW'(PCT_FULL)) ? PCT_FULL : div_quot[PCT_W-1:0];
	assign avg_cap  = (div_quot > NW'(AVG_MAX)) ? AVG_MAX : div_quot[AVG_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dz_q <= 1'b0;
		end else if (cmd.out_load) begin
			dz_q <= 1'b0;
		end else if (cmd.store && den_zero) begin
			dz_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store) begin
			unique case (cmd.op)
				OP_COV:  cov_q <= den_zero ? '0 : pct_cap;
				OP_BAD:  bp_q  <= den_zero ? '0 : pct_cap;
				OP_INV:  ip_q  <= den_zero ? '0 : pct_cap;
				OP_TOT:  tp_q  <= den_zero ? '0 : pct_cap;
				OP_AVG:  avg_q <= den_zero ? '0 : avg_cap;
				default: ;
			endcase
		end
	end

	// output register
	logic out_valid_q;

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			evaluated_count <= CNT_OUT_W'(eval_q);
			bad_count       <= CNT_OUT_W'(bad_q);
			invalid_count   <= CNT_OUT_W'(inv_q);
			error_sum       <= ERR_OUT_W'(err_q);
			coverage_pct    <= cov_q;
			bad_pct         <= bp_q;
			invalid_pct     <= ip_q;
			total_bad_pct   <= tp_q;
			avg_error       <= avg_q;
			divide_by_zero  <= dz_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* verif/disparity_error_statistics_tb.sv */
// ----------------------------------------------------------------------------
// Disparity error statistics: testbench
// Streams frames of truth/estimate pixels under several register settings,
// predicts each frame summary and checks every summary transfer field by field.
// ----------------------------------------------------------------------------
module disparity_error_statistics_tb import dstat_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam longint unsigned COUNT_SAT = (64'd1 << (DEF_MAX_PIXELS_LOG2 + 1)) - 1;
	localparam longint unsigned ERR_SAT   = (64'd1 << (DEF_MAX_PIXELS_LOG2 + 16)) - 1;

	typedef struct {
		bit               truth_known;
		bit [15:0]        truth_disp;
		bit               est_valid;
		bit signed [15:0] est_disp;
		bit [7:0]         mask_value;
		bit               last_pixel;
	} pixel_t;

	typedef struct {
		bit [CNT_OUT_W-1:0] evaluated_count;
		bit [CNT_OUT_W-1:0] bad_count;
		bit [CNT_OUT_W-1:0] invalid_count;
		bit [ERR_OUT_W-1:0] error_sum;
		bit [PCT_W-1:0]     coverage_pct;
		bit [PCT_W-1:0]     bad_pct;
		bit [PCT_W-1:0]     invalid_pct;
		bit [PCT_W-1:0]     total_bad_pct;
		bit [AVG_W-1:0]     avg_error;
		bit                 divide_by_zero;
	} summary_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_SCALE_LOG2;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               truth_known = 1'b0;
	logic [15:0]        truth_disp = '0;
	logic               est_valid = 1'b0;
	logic signed [15:0] est_disp = '0;
	logic [7:0]         mask_value = '0;
	logic               last_pixel = 1'b0;

	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [CNT_OUT_W-1:0] evaluated_count, bad_count, invalid_count;
	logic [ERR_OUT_W-1:0] error_sum;
	logic [PCT_W-1:0]     coverage_pct, bad_pct, invalid_pct, total_bad_pct;
	logic [AVG_W-1:0]     avg_error;
	logic                 divide_by_zero;

	disparity_error_statistics uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.truth_known(truth_known), .truth_disp(truth_disp),
		.est_valid(est_valid), .est_disp(est_disp),
		.mask_value(mask_value), .last_pixel(last_pixel),
		.out_valid(out_valid), .out_stall(out_stall),
		.evaluated_count(evaluated_count), .bad_count(bad_count),
		.invalid_count(invalid_count), .error_sum(error_sum),
		.coverage_pct(coverage_pct), .bad_pct(bad_pct),
		.invalid_pct(invalid_pct), .total_bad_pct(total_bad_pct),
		.avg_error(avg_error), .divide_by_zero(divide_by_zero)
	);

	always #5 clk = ~clk;

	// Testbench copy of the register file, updated only while the block is idle
	bit [1:0]  sh_scale_log2 = 2'd0;
	bit [9:0]  sh_max_disp = 10'd1023;
	bit [15:0] sh_bad_threshold = 16'd16;
	bit        sh_round_enable = 1'b0;
	bit        sh_use_mask = 1'b0;

	// Running frame totals of the predictor
	longint unsigned pix_tot = 0, eval_tot = 0, bad_tot = 0, inv_tot = 0, err_acc = 0;

	pixel_t   pixels_pending[$];
	summary_t summaries_due[$];
	pixel_t   on_bus;
	int       mismatches = 0;
	int       idle_cycles = 0;

	function automatic longint unsigned sat_count(longint unsigned v);
		return (v < COUNT_SAT) ? v + 1 : COUNT_SAT;
	endfunction

	function automatic longint unsigned percent_of(longint unsigned num, longint unsigned den);
		longint unsigned q;
		q = (num * 10000) / den;
		return (q > 10000) ? 10000 : q;
	endfunction

	// Folds one accepted pixel into the frame totals; closes the frame on last_pixel
	task automatic account_pixel(input pixel_t p);
		int unsigned    s;
		int             scaled;
		int unsigned    maxd, d, err;
		longint unsigned valid_n;
		longint unsigned avg;
		summary_t       sm;
		pix_tot = sat_count(pix_tot);
		if (p.truth_known && (!sh_use_mask || p.mask_value == MASK_EVAL)) begin
			eval_tot = sat_count(eval_tot);
			if (p.est_valid) begin
				s = (sh_scale_log2 > 2) ? 2 : sh_scale_log2;
				scaled = int'(p.est_disp) * (1 << s);
				maxd = (int'(sh_max_disp) << s) << DEF_FRAC_BITS;
				if (scaled < 0)
					d = 0;
				else if (scaled > maxd)
					d = maxd;
				else
					d = scaled;
				if (sh_round_enable)
					d = ((d + (1 << (DEF_FRAC_BITS - 1))) >> DEF_FRAC_BITS) << DEF_FRAC_BITS;
				err = (d > p.truth_disp) ? d - p.truth_disp : p.truth_disp - d;
				err_acc += err;
				if (err_acc > ERR_SAT)
					err_acc = ERR_SAT;
				if (err > sh_bad_threshold)
					bad_tot = sat_count(bad_tot);
			end else begin
				inv_tot = sat_count(inv_tot);
			end
		end
		if (p.last_pixel) begin
			valid_n = (eval_tot > inv_tot) ? eval_tot - inv_tot : 0;
			sm.evaluated_count = CNT_OUT_W'(eval_tot);
			sm.bad_count = CNT_OUT_W'(bad_tot);
			sm.invalid_count = CNT_OUT_W'(inv_tot);
			sm.error_sum = ERR_OUT_W'(err_acc);
			sm.coverage_pct = PCT_W'(percent_of(eval_tot, pix_tot));
			sm.divide_by_zero = 1'b0;
			if (eval_tot != 0) begin
				sm.bad_pct = PCT_W'(percent_of(bad_tot, eval_tot));
				sm.invalid_pct = PCT_W'(percent_of(inv_tot, eval_tot));
				sm.total_bad_pct = PCT_W'(percent_of(bad_tot + inv_tot, eval_tot));
			end else begin
				sm.bad_pct = '0;
				sm.invalid_pct = '0;
				sm.total_bad_pct = '0;
				sm.divide_by_zero = 1'b1;
			end
			if (valid_n != 0) begin
				avg = err_acc / valid_n;
				sm.avg_error = (avg > 65535) ? 16'hFFFF : AVG_W'(avg);
			end else begin
				sm.avg_error = '0;
				sm.divide_by_zero = 1'b1;
			end
			summaries_due = {summaries_due, sm};
			pix_tot = 0; eval_tot = 0; bad_tot = 0; inv_tot = 0; err_acc = 0;
		end
	endtask

	// ------------------------------------------------------------------------
	// Pixel driver: bursts of transfers separated by random gaps.
	// A stalled pixel is held unchanged; the predictor sees it on acceptance.
	// ------------------------------------------------------------------------
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				account_pixel(on_bus);
			if (in_valid && in_stall) begin
				// held
			end else if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pixels_pending.size() > 0) begin
				on_bus = pixels_pending.pop_front();
				in_valid <= 1'b1;
				truth_known <= on_bus.truth_known;
				truth_disp <= on_bus.truth_disp;
				est_valid <= on_bus.est_valid;
				est_disp <= on_bus.est_disp;
				mask_value <= on_bus.mask_value;
				last_pixel <= on_bus.last_pixel;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 15) : 0;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Summary receiver: stall behaviour switches at random between never
	// stalling, randomly scattered stalls and long stall runs.
	// ------------------------------------------------------------------------
	int rx_cycle = 0;
	int rx_mode = 0;
	int stall_left = 0;

	always @(posedge clk) begin
		rx_cycle++;
		if (rx_cycle % 256 == 0)
			rx_mode = $urandom_range(0, 2);
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (rx_mode == 1) begin
			out_stall <= ($urandom_range(0, 2) == 0);
		end else if (rx_mode == 2 && $urandom_range(0, 15) == 0) begin
			stall_left = $urandom_range(1, 40);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		$display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// Summary monitor: each transfer is compared with the oldest prediction
	always @(posedge clk) begin
		summary_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (summaries_due.size() == 0) begin
				$display("unexpected summary transfer at %0t", $realtime);
				mismatches++;
			end else begin
				w = summaries_due.pop_front();
				if (evaluated_count !== w.evaluated_count)
					report_mismatch("evaluated_count", evaluated_count, w.evaluated_count);
				if (bad_count !== w.bad_count)
					report_mismatch("bad_count", bad_count, w.bad_count);
				if (invalid_count !== w.invalid_count)
					report_mismatch("invalid_count", invalid_count, w.invalid_count);
				if (error_sum !== w.error_sum)
					report_mismatch("error_sum", error_sum, w.error_sum);
				if (coverage_pct !== w.coverage_pct)
					report_mismatch("coverage_pct", coverage_pct, w.coverage_pct);
				if (bad_pct !== w.bad_pct)
					report_mismatch("bad_pct", bad_pct, w.bad_pct);
				if (invalid_pct !== w.invalid_pct)
					report_mismatch("invalid_pct", invalid_pct, w.invalid_pct);
				if (total_bad_pct !== w.total_bad_pct)
					report_mismatch("total_bad_pct", total_bad_pct, w.total_bad_pct);
				if (avg_error !== w.avg_error)
					report_mismatch("avg_error", avg_error, w.avg_error);
				if (divide_by_zero !== w.divide_by_zero)
					report_mismatch("divide_by_zero", divide_by_zero, w.divide_by_zero);
			end
		end
	end

	// Watchdog: cycles in which neither channel makes a transfer
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("disparity_error_statistics_tb NOT OK");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	function automatic pixel_t make_pixel(input bit tk, input int td, input bit ev,
			input int ed, input int mv, input bit lp);
		pixel_t p;
		p.truth_known = tk; p.truth_disp = 16'(td); p.est_valid = ev;
		p.est_disp = 16'(ed); p.mask_value = 8'(mv); p.last_pixel = lp;
		return p;
	endfunction

	// Mostly estimates close to the truth so the threshold decides; some wild ones
	function automatic pixel_t random_pixel(input bit lp);
		pixel_t p;
		int     s;
		s = (sh_scale_log2 > 2) ? 2 : sh_scale_log2;
		p.truth_known = ($urandom_range(0, 9) != 0);
		p.truth_disp = 16'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 4000));
		p.est_valid = ($urandom_range(0, 7) != 0);
		if ($urandom_range(0, 2) == 0)
			p.est_disp = 16'($urandom);
		else
			p.est_disp = 16'((int'(p.truth_disp) >> s) + $signed($urandom_range(0, 64)) - 32);
		p.mask_value = ($urandom_range(0, 1) == 0) ? MASK_EVAL : 8'($urandom);
		p.last_pixel = lp;
		return p;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(val);
		case (idx)
			CFG_SCALE_LOG2:    sh_scale_log2 = 2'(val);
			CFG_MAX_DISP:      sh_max_disp = 10'(val);
			CFG_BAD_THRESHOLD: sh_bad_threshold = 16'(val);
			CFG_ROUND_ENABLE:  sh_round_enable = val[0];
			CFG_USE_MASK:      sh_use_mask = val[0];
			default: ;
		endcase
	endtask

	// Waits until every pixel is taken and every summary has come back
	task automatic drain();
		while (pixels_pending.size() != 0 || in_valid || summaries_due.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic random_frames(input int n_pixels);
		int left;
		int len;
		left = n_pixels;
		while (left > 0) begin
			len = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 40);
			if (len > left)
				len = left;
			for (int i = 0; i < len; i++)
				pixels_pending = {pixels_pending, random_pixel(i == len - 1)};
			left -= len;
		end
	endtask

	int unsigned phase_cfg[6][5] = '{
		'{1, 100,  0,     1, 1},
		'{2, 1023, 65535, 0, 0},
		'{3, 0,    32,    1, 0},
		'{0, 512,  8,     0, 1},
		'{2, 37,   100,   1, 1},
		'{1, 1023, 16,    0, 0}
	};

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames at reset defaults
		// frame with no known truth: every ratio but evaluated/total pixels divides by zero
		pixels_pending = {pixels_pending, make_pixel(0, 16'hFFFF, 1, 100, 255, 0)};
		pixels_pending = {pixels_pending, make_pixel(0, 0, 0, 0, 0, 1)};
		// only holes: average divides by zero, invalid at full scale
		pixels_pending = {pixels_pending, make_pixel(1, 0, 0, -32768, 255, 0)};
		pixels_pending = {pixels_pending, make_pixel(1, 65535, 0, 32767, 0, 1)};
		// single-pixel frame, error exactly at threshold (not bad)
		pixels_pending = {pixels_pending, make_pixel(1, 116, 1, 100, 255, 1)};
		// extremes: negative clip to 0, large estimate clipped to max, mask ignored
		pixels_pending = {pixels_pending, make_pixel(1, 65535, 1, -32768, 0, 0)};
		pixels_pending = {pixels_pending, make_pixel(1, 0, 1, 32767, 254, 0)};
		pixels_pending = {pixels_pending, make_pixel(1, 65535, 1, 32767, 255, 0)};
		pixels_pending = {pixels_pending, make_pixel(1, 0, 1, -1, 1, 0)};
		pixels_pending = {pixels_pending, make_pixel(1, 117, 1, 100, 128, 0)};
		pixels_pending = {pixels_pending, make_pixel(0, 500, 0, 16, 255, 1)};
		drain();

		foreach (phase_cfg[ph]) begin
			write_reg(CFG_SCALE_LOG2, phase_cfg[ph][0]);
			write_reg(CFG_MAX_DISP, phase_cfg[ph][1]);
			write_reg(CFG_BAD_THRESHOLD, phase_cfg[ph][2]);
			write_reg(CFG_ROUND_ENABLE, phase_cfg[ph][3]);
			write_reg(CFG_USE_MASK, phase_cfg[ph][4]);
			@(posedge clk);
			cfg_we <= 1'b0;
			// estimates halfway between rounding steps before scaling, and mask boundary, at each setting
			pixels_pending = {pixels_pending, make_pixel(1, 40, 1, 8, 255, 0)};
			pixels_pending = {pixels_pending, make_pixel(1, 40, 1, 24, 254, 0)};
			pixels_pending = {pixels_pending, make_pixel(1, 40, 1, 7, 255, 1)};
			random_frames(180);
			drain();
		end

		repeat (250) @(posedge clk);
		if (mismatches == 0 && summaries_due.size() == 0)
			$display("disparity_error_statistics_tb OK");
		else
			$display("disparity_error_statistics_tb NOT OK");
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl
rtl/dstat_pkg.sv
rtl/dstat_div.sv
rtl/dstat_ctrl.sv
rtl/dstat_datapath.sv
rtl/disparity_error_statistics.sv
verif/disparity_error_statistics_tb.sv
